// File: rtl/assert_macros.svh
// Assertion macros used by the RTL top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds on every clock edge outside reset
`define SRRB_ASSERT(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Antecedent in one cycle implies consequent in the next
`define SRRB_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// File: rtl/srrb_pkg.sv
// Package for the sequenced retention ring buffer: types, constants and codes
`timescale 1ns / 1ps
`default_nettype none

package srrb_pkg;

    // Ring depth, a power of two so that indexes wrap by truncation
    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic [1:0] FUNC_PUB = 2'd0;
    localparam logic [1:0] FUNC_GET = 2'd1;
    localparam logic [1:0] FUNC_EXP = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_REFUSED = 2'd1;
    localparam logic [1:0] ST_NONE    = 2'd0;
    localparam logic [1:0] ST_EXACT   = 2'd1;
    localparam logic [1:0] ST_LATER   = 2'd2;
    localparam logic [1:0] ST_REMOVED = 2'd1;

    localparam logic [0:0] REG_MAX_AGE = 1'b0;
    localparam logic [31:0] MAX_AGE_RESET = 32'd1000000;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] now_time;
        logic [7:0]  pub_id;
        logic [31:0] payload;
        logic [31:0] last_seq;
    } srrb_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] seq_out;
        logic [7:0]  pub_id_out;
        logic [31:0] payload_out;
        logic [31:0] stamp_out;
    } srrb_out_t;

    typedef struct packed {
        logic [31:0] seq;
        logic [31:0] stamp;
        logic [7:0]  pub_id;
        logic [31:0] payload;
    } srrb_entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_EMIT
    } srrb_state_t;

    // Controller to datapath
    typedef struct packed {
        logic start;
        logic step;
        logic finish;
        logic emit;
    } srrb_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic walk_done;
        logic out_free;
    } srrb_sts_t;

endpackage

`default_nettype wire

// File: rtl/srrb_ctrl.sv
// Controller state machine for the sequenced retention ring buffer
`timescale 1ns / 1ps
`default_nettype none

module srrb_ctrl (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    input  srrb_pkg::srrb_sts_t sts,
    output srrb_pkg::srrb_cmd_t cmd
);
    import srrb_pkg::*;

    srrb_state_t state_reg;
    srrb_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK: begin
                if (sts.walk_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready   = 1'b1;
                cmd.start = s_valid;
            end
            ST_WALK: begin
                cmd.finish = sts.walk_done;
                cmd.step   = !sts.walk_done;
            end
            ST_EMIT: begin
                cmd.emit = sts.out_free;
            end
            default: begin
                cmd     = '0;
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/srrb_dp.sv
// Datapath: ring storage, pointers, entry walk and result registers
`timescale 1ns / 1ps
`default_nettype none

module srrb_dp (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  srrb_pkg::srrb_cmd_t cmd,
    output srrb_pkg::srrb_sts_t sts,
    input  srrb_pkg::srrb_in_t  s_data,
    input  wire [31:0]          max_age,
    output logic                m_valid,
    input  wire                 m_ready,
    output srrb_pkg::srrb_out_t m_data
);
    import srrb_pkg::*;

    srrb_entry_t mem [DEPTH];

    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic             empty_reg, empty_next;
    logic [31:0]      next_seq_reg, next_seq_next;
    logic [IDX_W-1:0] idx_reg;
    srrb_in_t         req_reg;
    srrb_entry_t      rd_data_reg;
    srrb_out_t        res_reg, res_next;
    logic             m_valid_reg;
    srrb_out_t        m_data_reg;

    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] wr_slot;
    logic             wr_en;
    logic [IDX_W-1:0] diff;
    logic [CNT_W-1:0] cnt;
    logic             last;
    logic [32:0]      want;
    logic             seq_ge;
    logic             seq_eq;
    logic [31:0]      age;
    logic             young;
    logic             hit;
    logic [CNT_W-1:0] n_rm;

    assign diff = tail_reg - head_reg;
    assign cnt  = empty_reg ? CNT_W'(0) : CNT_W'({1'b0, diff}) + CNT_W'(1);
    assign last = (CNT_W'({1'b0, idx_reg}) == cnt - CNT_W'(1));

    assign rd_addr = cmd.start ? head_reg : head_reg + idx_reg + IDX_W'(1);

    assign want   = {1'b0, req_reg.last_seq} + 33'd1;
    assign seq_ge = ({1'b0, rd_data_reg.seq} >= want);
    assign seq_eq = ({1'b0, rd_data_reg.seq} == want);
    assign age    = req_reg.now_time - rd_data_reg.stamp;
    assign young  = (age < max_age);
    assign hit    = (req_reg.func == FUNC_GET) ? seq_ge : young;

    always_comb begin
        sts.out_free = !m_valid_reg || m_ready;
        case (req_reg.func)
            FUNC_GET, FUNC_EXP: sts.walk_done = (cnt == CNT_W'(0)) || hit || last;
            default:            sts.walk_done = 1'b1;
        endcase
    end

    // Result and state updates, committed on finish
    always_comb begin
        head_next     = head_reg;
        tail_next     = tail_reg;
        empty_next    = empty_reg;
        next_seq_next = next_seq_reg;
        res_next      = '0;
        wr_en         = 1'b0;
        wr_slot       = empty_reg ? IDX_W'(0) : tail_reg + IDX_W'(1);
        n_rm          = '0;
        case (req_reg.func)
            FUNC_PUB: begin
                if (cnt == CNT_W'(DEPTH) || next_seq_reg == 32'd0) begin
                    res_next.status = ST_REFUSED;
                end else begin
                    wr_en                = 1'b1;
                    head_next            = empty_reg ? IDX_W'(0) : head_reg;
                    tail_next            = wr_slot;
                    empty_next           = 1'b0;
                    next_seq_next        = next_seq_reg + 32'd1;
                    res_next.status      = ST_OK;
                    res_next.seq_out     = next_seq_reg;
                    res_next.pub_id_out  = req_reg.pub_id;
                    res_next.payload_out = req_reg.payload;
                    res_next.stamp_out   = req_reg.now_time;
                end
            end
            FUNC_GET: begin
                if (cnt != CNT_W'(0) && seq_ge) begin
                    res_next.status      = seq_eq ? ST_EXACT : ST_LATER;
                    res_next.seq_out     = rd_data_reg.seq;
                    res_next.pub_id_out  = rd_data_reg.pub_id;
                    res_next.payload_out = rd_data_reg.payload;
                    res_next.stamp_out   = rd_data_reg.stamp;
                end else begin
                    res_next.status = ST_NONE;
                end
            end
            FUNC_EXP: begin
                if (cnt == CNT_W'(0)) begin
                    n_rm = '0;
                end else if (young) begin
                    n_rm = CNT_W'({1'b0, idx_reg});
                end else begin
                    n_rm = cnt;
                end
                if (n_rm == CNT_W'(0)) begin
                    res_next.status = ST_NONE;
                end else if (n_rm == cnt) begin
                    res_next.status = ST_REMOVED;
                    empty_next      = 1'b1;
                    head_next       = '0;
                    tail_next       = '0;
                end else begin
                    res_next.status = ST_REMOVED;
                    head_next       = head_reg + n_rm[IDX_W-1:0];
                end
            end
            default: res_next = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg     <= '0;
            tail_reg     <= '0;
            empty_reg    <= 1'b1;
            next_seq_reg <= 32'd1;
            idx_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cmd.start) begin
                idx_reg <= '0;
            end else if (cmd.step) begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
            if (cmd.finish) begin
                head_reg     <= head_next;
                tail_reg     <= tail_next;
                empty_reg    <= empty_next;
                next_seq_reg <= next_seq_next;
            end
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            req_reg <= s_data;
        end
        if (cmd.finish) begin
            res_reg <= res_next;
        end
        if (cmd.emit) begin
            m_data_reg <= res_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish && wr_en) begin
            mem[wr_slot] <= '{seq: next_seq_reg, stamp: req_reg.now_time,
                              pub_id: req_reg.pub_id, payload: req_reg.payload};
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

// File: rtl/sequenced_retention_ring_buffer_core.sv
// Top level of the sequenced retention ring buffer with its register port
//
// Requests arrive on s_valid/s_ready/s_data: publish, get-next or expire.
// Each request yields exactly one result on m_valid/m_ready/m_data.
// One request is in work at a time. Publish and undefined codes need no
// walk; get-next and expire walk the stored entries from the head,
// one per cycle through the registered ring read port, stopping early on a
// match, so at most 16 entries are examined per request.
// The result register lets a new request be accepted while the previous
// result still waits; a stalled receiver only holds the block once the
// next result is ready, in which case it waits in its output stage.
// max_age is written over the APB port at address 0 (decoded from paddr[2]
// alone, so addresses 1 to 3 alias it); the user must write it only while
// idle, which the block itself does not enforce. Synchronous active-low
// reset empties the ring, sets the sequence counter to one and max_age to
// 1000000; ring contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module sequenced_retention_ring_buffer_core (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    input  srrb_pkg::srrb_in_t  s_data,
    output logic                m_valid,
    input  wire                 m_ready,
    output srrb_pkg::srrb_out_t m_data,
    input  wire                 psel,
    input  wire                 penable,
    input  wire                 pwrite,
    input  wire [2:0]           paddr,
    input  wire [31:0]          pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import srrb_pkg::*;

    srrb_cmd_t   cmd;
    srrb_sts_t   sts;
    logic [31:0] max_age_reg;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_age_reg <= MAX_AGE_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_MAX_AGE) begin
            max_age_reg <= pwdata;
        end
    end

    assign prdata = (paddr[2] == REG_MAX_AGE) ? max_age_reg : 32'd0;

    srrb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    srrb_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .sts     (sts),
        .s_data  (s_data),
        .max_age (max_age_reg),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    `SRRB_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready, "overrun")
    `SRRB_ASSERT(a_emit_free, aclk, aresetn, !cmd.emit || sts.out_free, "result overwritten")
    `SRRB_ASSERT(a_cmd_onehot, aclk, aresetn, $onehot0(cmd), "conflicting commands")

endmodule

`default_nettype wire

// File: test/sequenced_retention_ring_buffer_core_test.sv
// Self-checking testbench for the sequenced retention ring buffer core
`timescale 1ns / 1ps

module sequenced_retention_ring_buffer_core_test;
    import srrb_pkg::*;

    localparam logic [1:0] FUNC_UNDEF = 2'd3;
    localparam int PHASES = 6;
    localparam int PHASE_ITEMS = 225;
    localparam int PRESSURE_PHASE = 2;
    localparam int CALM_PHASE = 4;
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 80;
    localparam srrb_out_t NOTHING = '0;
    localparam srrb_out_t REFUSED = '{ST_REFUSED, 32'd0, 8'd0, 32'd0, 32'd0};

    typedef struct packed {
        srrb_in_t  req;
        logic      fixed;
        srrb_out_t res;
    } plan_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    srrb_in_t    s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    srrb_out_t   m_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // Mirror of the ring
    srrb_entry_t      ring_entry [DEPTH];
    logic [IDX_W-1:0] ring_head = '0;
    logic [IDX_W-1:0] ring_tail = '0;
    logic             ring_is_empty = 1'b1;
    logic [31:0]      seq_next = 32'd1;
    logic [31:0]      age_limit = MAX_AGE_RESET;

    srrb_out_t   awaited_results [$];
    int          fault_count = 0;
    logic [31:0] wall_time;
    bit          steady = 1'b0;
    logic        hold_req = 1'b0;

    // Extremes, every request type, exact/later/none lookups, partial and full expiry
    plan_row_t directed_plan [14] = '{
        '{'{FUNC_GET, 32'd0, 8'd0, 32'd0, 32'd0}, 1'b1, NOTHING},
        '{'{FUNC_EXP, 32'd0, 8'd0, 32'd0, 32'd0}, 1'b1, NOTHING},
        '{'{FUNC_UNDEF, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1, NOTHING},
        '{'{FUNC_PUB, 32'd0, 8'd0, 32'd0, 32'd0}, 1'b1,
          '{ST_OK, 32'd1, 8'd0, 32'd0, 32'd0}},
        '{'{FUNC_PUB, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF, 32'd0}, 1'b1,
          '{ST_OK, 32'd2, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}},
        '{'{FUNC_PUB, 32'd100, 8'h5A, 32'hA5A5_A5A5, 32'd0}, 1'b1,
          '{ST_OK, 32'd3, 8'h5A, 32'hA5A5_A5A5, 32'd100}},
        '{'{FUNC_GET, 32'd0, 8'd0, 32'd0, 32'd0}, 1'b1,
          '{ST_EXACT, 32'd1, 8'd0, 32'd0, 32'd0}},
        '{'{FUNC_GET, 32'd0, 8'd0, 32'd0, 32'd2}, 1'b0, NOTHING},
        '{'{FUNC_GET, 32'd0, 8'd0, 32'd0, 32'd3}, 1'b1, NOTHING},
        '{'{FUNC_GET, 32'd0, 8'd0, 32'd0, 32'hFFFF_FFFF}, 1'b1, NOTHING},
        '{'{FUNC_EXP, 32'd1000000, 8'd0, 32'd0, 32'd0}, 1'b0, NOTHING},
        '{'{FUNC_GET, 32'd0, 8'd0, 32'd0, 32'd0}, 1'b0, NOTHING},
        '{'{FUNC_EXP, 32'd1000100, 8'd0, 32'd0, 32'd0}, 1'b0, NOTHING},
        '{'{FUNC_PUB, 32'd5, 8'hC3, 32'h3C3C_3C3C, 32'd0}, 1'b0, NOTHING}
    };

    sequenced_retention_ring_buffer_core dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #10 aclk = ~aclk;

    function automatic srrb_out_t entry_result(input logic [1:0] code, input srrb_entry_t e);
        return '{code, e.seq, e.pub_id, e.payload, e.stamp};
    endfunction

    function automatic srrb_out_t ring_apply(input srrb_in_t req);
        srrb_out_t        res;
        logic [IDX_W-1:0] span;
        logic [IDX_W-1:0] slot;
        logic [32:0]      want;
        int               fill;
        int               k;
        res = '0;
        span = ring_tail - ring_head;
        fill = ring_is_empty ? 0 : int'(span) + 1;
        case (req.func)
            FUNC_PUB: begin
                if (fill >= DEPTH || seq_next == 32'd0) begin
                    res.status = ST_REFUSED;
                end else begin
                    if (ring_is_empty) begin
                        ring_head = '0;
                        ring_tail = '0;
                        ring_is_empty = 1'b0;
                    end else begin
                        ring_tail = ring_tail + 1'b1;
                    end
                    ring_entry[ring_tail] = '{seq_next, req.now_time, req.pub_id, req.payload};
                    seq_next = seq_next + 32'd1;
                    res = entry_result(ST_OK, ring_entry[ring_tail]);
                end
            end
            FUNC_GET: begin
                want = {1'b0, req.last_seq} + 33'd1;
                for (k = 0; k < fill; k++) begin
                    slot = ring_head + k[IDX_W-1:0];
                    if ({1'b0, ring_entry[slot].seq} == want)
                        return entry_result(ST_EXACT, ring_entry[slot]);
                end
                for (k = 0; k < fill; k++) begin
                    slot = ring_head + k[IDX_W-1:0];
                    if ({1'b0, ring_entry[slot].seq} > want)
                        return entry_result(ST_LATER, ring_entry[slot]);
                end
            end
            FUNC_EXP: begin
                for (k = 0; k < fill; k++) begin
                    slot = ring_head + k[IDX_W-1:0];
                    if (req.now_time - ring_entry[slot].stamp < age_limit)
                        break;
                end
                if (k != 0) begin
                    res.status = ST_REMOVED;
                    if (k == fill) begin
                        ring_is_empty = 1'b1;
                        ring_head = '0;
                        ring_tail = '0;
                    end else begin
                        ring_head = ring_head + k[IDX_W-1:0];
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic int gap_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return $urandom_range(1, 3);
        if (roll < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Mostly coherent traffic around the live sequence window and the current time
    function automatic srrb_in_t make_request();
        srrb_in_t req;
        int       pick;
        req.pub_id = 8'($urandom);
        req.payload = $urandom;
        req.last_seq = $urandom;
        wall_time = wall_time + $urandom_range(0, 30);
        req.now_time = ($urandom_range(0, 19) == 0) ? $urandom : wall_time;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            req.func = FUNC_PUB;
        end else if (pick < 80) begin
            req.func = FUNC_GET;
            pick = $urandom_range(0, 9);
            if (pick < 7)
                req.last_seq = seq_next - 32'd1 - $urandom_range(0, 20);
            else if (pick == 7)
                req.last_seq = 32'hFFFF_FFFF;
        end else if (pick < 96) begin
            req.func = FUNC_EXP;
            if (!ring_is_empty && $urandom_range(0, 2) == 0)
                req.now_time = ring_entry[ring_head].stamp + age_limit - $urandom_range(0, 1);
        end else begin
            req.func = FUNC_UNDEF;
        end
        return req;
    endfunction

    task automatic flag(input string field, input logic [31:0] want, input logic [31:0] got);
        $display("%0t %s expected %h got %h", $time, field, want, got);
        fault_count++;
    endtask

    task automatic take(input srrb_out_t got);
        srrb_out_t want;
        if (awaited_results.size() == 0) begin
            $display("%0t result expected none got %h", $time, got);
            fault_count++;
        end else begin
            want = awaited_results.pop_front();
            if (got.status !== want.status)
                flag("status", want.status, got.status);
            if (got.seq_out !== want.seq_out)
                flag("seq_out", want.seq_out, got.seq_out);
            if (got.pub_id_out !== want.pub_id_out)
                flag("pub_id_out", want.pub_id_out, got.pub_id_out);
            if (got.payload_out !== want.payload_out)
                flag("payload_out", want.payload_out, got.payload_out);
            if (got.stamp_out !== want.stamp_out)
                flag("stamp_out", want.stamp_out, got.stamp_out);
        end
    endtask

    task automatic send(input srrb_in_t req, input logic fixed, input srrb_out_t fixed_res);
        srrb_out_t predicted;
        s_data <= req;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        predicted = ring_apply(req);
        awaited_results.push_back(fixed ? fixed_res : predicted);
        if (!steady && $urandom_range(0, 99) >= 55) begin
            s_valid <= 1'b0;
            repeat (gap_len()) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge aclk);
    endtask

    task automatic apb_access(input logic wr, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {REG_MAX_AGE, 2'b00};
        pwdata <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        if (wr)
            age_limit = wdata;
        @(posedge aclk);
    endtask

    task automatic check_age();
        logic [31:0] readback;
        apb_access(1'b0, 32'd0, readback);
        if (readback !== age_limit)
            flag("max_age", age_limit, readback);
    endtask

    initial begin : stimulus
        logic [31:0] age_plan [PHASES];
        logic [31:0] scratch;
        int          k;
        int          phase;
        wall_time = $urandom;
        age_plan = '{MAX_AGE_RESET, 32'd0, 32'd150, 32'hFFFF_FFFF,
                     $urandom_range(40, 400), $urandom};
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        check_age();

        foreach (directed_plan[i])
            send(directed_plan[i].req, directed_plan[i].fixed, directed_plan[i].res);
        // fill the ring; the last publish meets a full ring
        for (k = 0; k < DEPTH; k++)
            send('{FUNC_PUB, wall_time + k, 8'($urandom), $urandom, $urandom},
                 k == DEPTH - 1, REFUSED);

        for (phase = 0; phase < PHASES; phase++) begin
            drain();
            apb_access(1'b1, age_plan[phase], scratch);
            check_age();
            steady = (phase == PRESSURE_PHASE || phase == CALM_PHASE);
            if (phase == PRESSURE_PHASE)
                hold_req <= 1'b1;
            repeat (PHASE_ITEMS) send(make_request(), 1'b0, NOTHING);
        end
        drain();
        steady = 1'b1;
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fault_count == 0)
            $display("sequenced_retention_ring_buffer_core: match");
        else
            $display("sequenced_retention_ring_buffer_core: mismatch");
        $finish;
    end

    initial begin : result_sink
        int stall;
        stall = 0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (m_valid && m_ready)
                take(m_data);
            if (hold_req) begin
                stall = HOLD_CYCLES;
                hold_req <= 1'b0;
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                stall--;
            end else if (steady || $urandom_range(0, 99) < 70) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b0;
                stall = gap_len() - 1;
            end
            @(posedge aclk);
        end
    end

    initial begin : watchdog
        #(30_000_000);
        $display("sequenced_retention_ring_buffer_core: mismatch");
        $finish;
    end

endmodule
